// ===== sv/dlss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dlss_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [2:0] PHASE_SAMPLE = 3'd4;

  // q_mode codes, bit 1 is Q7, bit 0 is Q6
  localparam logic [1:0] QM_READ    = 2'd0;
  localparam logic [1:0] QM_SENSE   = 2'd1;
  localparam logic [1:0] QM_WRITE   = 2'd2;
  localparam logic [1:0] QM_LOAD    = 2'd3;

  // data register actions, low nibble of a sequencer word; 0..7 clear
  localparam logic [3:0] ACT_NOP_A  = 4'h8;
  localparam logic [3:0] ACT_SL0    = 4'h9;
  localparam logic [3:0] ACT_SR_A   = 4'hA;
  localparam logic [3:0] ACT_LD_A   = 4'hB;
  localparam logic [3:0] ACT_NOP_B  = 4'hC;
  localparam logic [3:0] ACT_SL1    = 4'hD;
  localparam logic [3:0] ACT_SR_B   = 4'hE;
  localparam logic [3:0] ACT_LD_B   = 4'hF;

  typedef struct packed {
    logic       drive_enabled;
    logic       write_protect;
    logic [7:0] bus_data;
    logic [1:0] q_mode;
    logic       disk_bit;
    logic       disk_present;
  } dlss_item_t;

  typedef struct packed {
    logic [3:0] seq_state;
    logic       write_flux;
    logic       write_strobe;
    logic       bit_taken;
    logic [7:0] data_latch;
  } dlss_result_t;

  typedef struct packed {
    logic [3:0] seq_state;
    logic [7:0] data_reg;
    logic [2:0] phase;
    logic       write_level;
  } dlss_state_t;

  // sequencer ROM: next state in the high nibble, action in the low nibble
  localparam logic [7:0] SEQ_ROM [256] = '{
    8'h18,8'h18,8'h18,8'h18,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,
    8'h2D,8'h2D,8'h38,8'h38,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,
    8'hD8,8'h38,8'h08,8'h28,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h39,8'h39,8'h39,8'h39,8'h3B,8'h3B,8'h3B,8'h3B,
    8'hD8,8'h48,8'h48,8'h48,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,
    8'hD8,8'h58,8'hD8,8'h58,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,
    8'hD8,8'h68,8'hD8,8'h68,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,
    8'hD8,8'h78,8'hD8,8'h78,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,
    8'hD8,8'h88,8'hD8,8'h88,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h08,8'h08,8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,
    8'hD8,8'h98,8'hD8,8'h98,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,
    8'hD8,8'h29,8'hD8,8'hA8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,
    8'hCD,8'hBD,8'hD8,8'hB8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hB9,8'hB9,8'hB9,8'hB9,8'hBB,8'hBB,8'hBB,8'hBB,
    8'hD9,8'h59,8'hD8,8'hC8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,
    8'hD9,8'hD9,8'hD8,8'hA0,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,
    8'hD8,8'h08,8'hE8,8'hE8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,
    8'hFD,8'hFD,8'hF8,8'hF8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,
    8'hDD,8'h4D,8'hE0,8'hE0,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,8'h08,8'h08
  };

endpackage
`default_nettype wire

// ===== sv/disk_logic_state_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  tdata fields (low bit up)                               handshake
// in_      in   disk_present, disk_bit, q_mode, bus_data, write_protect,  tvalid/tready
//               drive_enabled, 2 pad bits
// out_     out  data_latch, bit_taken, write_strobe, write_flux,          tvalid/tready
//               seq_state, 1 pad bit
// One item per clock while out_ is not stalled; each item sees an input register, the ROM
// lookup and action logic, then the result register on its way from in_ to out_.
// Sequencer state updates when an item moves from the input to the result register.
// A stalled out_ holds its item while one more item waits in the input register.
// rst_n is synchronous; it clears both stage valids and the sequencer state.
module disk_logic_state_sequencer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // disk_present, disk_bit, q_mode[1:0], bus_data[7:0], write_protect, drive_enabled
  input  wire logic [dlss_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // data_latch[7:0], bit_taken, write_strobe, write_flux, seq_state[3:0]
  output logic [dlss_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import dlss_pkg::*;

  logic         in_valid_r;
  dlss_item_t   in_item_r;
  logic         out_valid_r;
  dlss_result_t out_res_r;
  dlss_state_t  state_r;
  dlss_state_t  state_nxt;
  dlss_result_t res_nxt;
  logic         advance;

  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  dlss_step u_step (
    .cur  (state_r),
    .item (in_item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= dlss_item_t'(in_tdata[$bits(dlss_item_t)-1:0]);
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-$bits(dlss_result_t)){1'b0}}, out_res_r};

`ifndef SYNTHESIS
  // a tick never both reads and writes the head
  a_read_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_res_r.bit_taken && out_res_r.write_strobe))
    else $error("bit_taken and write_strobe both set");

  // flux only on a write tick
  a_flux_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.write_flux |-> out_res_r.write_strobe)
    else $error("write_flux without write_strobe");

  // phase counter moves by one per processed item
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> state_r.phase == $past(state_r.phase) + 3'd1)
    else $error("phase counter skipped");

  // the result register reports the committed sequencer state
  a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_res_r.seq_state == state_r.seq_state
                && out_res_r.data_latch == state_r.data_reg)
    else $error("result does not match sequencer state");
`endif

endmodule
`default_nettype wire

// ===== sv/dlss_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dlss_step (
  input  wire dlss_pkg::dlss_state_t  cur,
  input  wire dlss_pkg::dlss_item_t   item,
  output dlss_pkg::dlss_state_t  nxt,
  output dlss_pkg::dlss_result_t res
);
  import dlss_pkg::*;

  logic       phase4;
  logic       q7;
  logic       pulse;
  logic       taken;
  logic       strobe;
  logic [7:0] addr;
  logic [7:0] op;
  logic [3:0] next_state;
  logic [7:0] reg_act;

  assign phase4 = (cur.phase == PHASE_SAMPLE);
  assign q7     = item.q_mode[1];
  assign taken  = item.disk_present & phase4 & ~q7;
  assign pulse  = taken & item.disk_bit;
  assign addr   = {cur.seq_state, item.q_mode, cur.data_reg[7], ~pulse};
  assign op     = SEQ_ROM[addr];
  assign next_state = op[7:4];
  assign strobe = item.disk_present & phase4 & q7 & item.drive_enabled;

  always_comb begin
    case (op[3:0]) inside
      ACT_NOP_A, ACT_NOP_B: reg_act = cur.data_reg;
      ACT_SL0:              reg_act = {cur.data_reg[6:0], 1'b0};
      ACT_SL1:              reg_act = {cur.data_reg[6:0], 1'b1};
      ACT_SR_A, ACT_SR_B:   reg_act = {item.write_protect, cur.data_reg[7:1]};
      ACT_LD_A, ACT_LD_B:   reg_act = item.bus_data;
      default:              reg_act = 8'h00; // codes 0..7 clear
    endcase
  end

  always_comb begin
    nxt       = cur;
    nxt.phase = cur.phase + 3'd1;
    if (item.disk_present) begin
      nxt.seq_state = next_state;
      nxt.data_reg  = reg_act;
      if (strobe) begin
        nxt.write_level = next_state[3];
      end
    end
  end

  assign res.data_latch   = nxt.data_reg;
  assign res.seq_state    = nxt.seq_state;
  assign res.bit_taken    = taken;
  assign res.write_strobe = strobe;
  assign res.write_flux   = strobe & (next_state[3] ^ cur.write_level);

endmodule
`default_nettype wire

// ===== dv/disk_logic_state_sequencer_tb.sv =====
`timescale 1ns / 1ps
module disk_logic_state_sequencer_tb;
  import dlss_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tready;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  disk_logic_state_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // next state in the high nibble, data register action in the low nibble
  logic [7:0] ctrl_rom [256] = '{
    8'h18,8'h18,8'h18,8'h18,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,
    8'h2D,8'h2D,8'h38,8'h38,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,
    8'hD8,8'h38,8'h08,8'h28,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h39,8'h39,8'h39,8'h39,8'h3B,8'h3B,8'h3B,8'h3B,
    8'hD8,8'h48,8'h48,8'h48,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,
    8'hD8,8'h58,8'hD8,8'h58,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,
    8'hD8,8'h68,8'hD8,8'h68,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,
    8'hD8,8'h78,8'hD8,8'h78,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,
    8'hD8,8'h88,8'hD8,8'h88,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h08,8'h08,8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,
    8'hD8,8'h98,8'hD8,8'h98,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,
    8'hD8,8'h29,8'hD8,8'hA8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,
    8'hCD,8'hBD,8'hD8,8'hB8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hB9,8'hB9,8'hB9,8'hB9,8'hBB,8'hBB,8'hBB,8'hBB,
    8'hD9,8'h59,8'hD8,8'hC8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,
    8'hD9,8'hD9,8'hD8,8'hA0,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,
    8'hD8,8'h08,8'hE8,8'hE8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,
    8'hFD,8'hFD,8'hF8,8'hF8,8'h0A,8'h0A,8'h0A,8'h0A,
    8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,
    8'hDD,8'h4D,8'hE0,8'hE0,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,8'h08,8'h08
  };

  // shadow copy of the controller state
  logic [3:0] sq_state = '0;
  logic [7:0] sq_data = '0;
  logic [2:0] sq_phase = '0;
  logic       sq_level = 1'b0;

  dlss_item_t   tick_queue [$];
  dlss_result_t due_results [$];
  int err_count = 0;
  int results_seen = 0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  logic hold_off = 1'b0;
  logic in_burst = 1'b0;
  logic out_burst = 1'b0;
  int in_gap = 0;
  int out_wait = 0;

  task automatic advance_sequencer(input dlss_item_t it, output dlss_result_t r);
    logic       pulse;
    logic       q7;
    logic       at_sample;
    logic [7:0] addr;
    logic [7:0] word;
    logic [3:0] nxt;
    r = '0;
    q7 = it.q_mode[1];
    at_sample = (sq_phase == PHASE_SAMPLE);
    if (it.disk_present) begin
      pulse = 1'b0;
      if (at_sample && !q7) begin
        pulse = it.disk_bit;
        r.bit_taken = 1'b1;
      end
      addr = {sq_state, it.q_mode, sq_data[7], ~pulse};
      word = ctrl_rom[addr];
      nxt = word[7:4];
      case (word[3:0])
        ACT_NOP_A, ACT_NOP_B: ;
        ACT_SL0: sq_data = {sq_data[6:0], 1'b0};
        ACT_SL1: sq_data = {sq_data[6:0], 1'b1};
        ACT_SR_A, ACT_SR_B: sq_data = {it.write_protect, sq_data[7:1]};
        ACT_LD_A, ACT_LD_B: sq_data = it.bus_data;
        default: sq_data = '0;
      endcase
      // write level follows the top bit of the next state
      if (at_sample && q7 && it.drive_enabled) begin
        r.write_strobe = 1'b1;
        r.write_flux = nxt[3] ^ sq_level;
        sq_level = nxt[3];
      end
      sq_state = nxt;
    end
    sq_phase = sq_phase + 3'd1;
    r.data_latch = sq_data;
    r.seq_state = sq_state;
  endtask

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  function automatic dlss_item_t make_tick(logic present, logic dbit, logic [1:0] qm,
                                           logic [7:0] bus, logic wp, logic en);
    dlss_item_t it;
    it.disk_present = present;
    it.disk_bit = dbit;
    it.q_mode = qm;
    it.bus_data = bus;
    it.write_protect = wp;
    it.drive_enabled = en;
    return it;
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        in_tdata <= IN_TDATA_W'(tick_queue.pop_front());
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 31) == 0) in_burst = ~in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (out_took) begin
      if ($urandom_range(0, 31) == 0) out_burst = ~out_burst;
      out_wait = out_burst ? 0 : $urandom_range(0, 15);
      out_tready <= (out_wait == 0);
    end else if (out_wait > 0) begin
      out_wait--;
      out_tready <= (out_wait == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // one long receiver stall mid-run so both stages fill and in_tready drops
  initial begin
    wait (results_seen >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    dlss_result_t got;
    dlss_result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      out_took <= out_tvalid && out_tready;
      // output first: a result can never come from the item taken at this edge
      if (out_tvalid && out_tready) begin
        got = dlss_result_t'(out_tdata[$bits(dlss_result_t)-1:0]);
        results_seen++;
        if (due_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected item expected none actual %h", $time, got);
        end else begin
          want = due_results.pop_front();
          cmp_field("data_latch", want.data_latch, got.data_latch);
          cmp_field("bit_taken", want.bit_taken, got.bit_taken);
          cmp_field("write_strobe", want.write_strobe, got.write_strobe);
          cmp_field("write_flux", want.write_flux, got.write_flux);
          cmp_field("seq_state", want.seq_state, got.seq_state);
        end
      end
      if (in_tvalid && in_tready) begin
        advance_sequencer(dlss_item_t'(in_tdata[$bits(dlss_item_t)-1:0]), want);
        due_results.push_back(want);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int         kind;
    int         len;
    int         target;
    int         bits_left;
    logic [7:0] rd_byte;
    logic [7:0] bus;
    logic       wp;
    logic       en;
    logic       dbit;

    // no disk: only the phase moves, whatever the other fields say
    tick_queue.push_back(make_tick(1'b0, 1'b1, QM_LOAD, 8'hFF, 1'b1, 1'b1));
    tick_queue.push_back(make_tick(1'b0, 1'b0, QM_READ, 8'h00, 1'b0, 1'b0));
    tick_queue.push_back(make_tick(1'b0, 1'b1, QM_WRITE, 8'h80, 1'b1, 1'b1));
    tick_queue.push_back(make_tick(1'b0, 1'b1, QM_SENSE, 8'h01, 1'b0, 1'b1));
    // read mode, phase 4 lands on the first of these; disk bit ignored elsewhere
    for (int k = 0; k < 8; k++)
      tick_queue.push_back(make_tick(1'b1, k[0] | (k == 0), QM_READ, 8'h00, 1'b0, 1'b0));
    // load extremes
    tick_queue.push_back(make_tick(1'b1, 1'b0, QM_LOAD, 8'hFF, 1'b0, 1'b1));
    tick_queue.push_back(make_tick(1'b1, 1'b1, QM_LOAD, 8'h00, 1'b1, 1'b0));
    // protect sense shifts write_protect in from the top
    for (int k = 0; k < 4; k++)
      tick_queue.push_back(make_tick(1'b1, 1'b1, QM_SENSE, 8'hFF, ~k[0], 1'b1));
    // write mode through phase 4 with the head enabled, then with it disabled
    for (int k = 0; k < 8; k++)
      tick_queue.push_back(make_tick(1'b1, 1'b1, QM_WRITE, 8'hA5, 1'b0, 1'b1));
    for (int k = 0; k < 8; k++)
      tick_queue.push_back(make_tick(1'b1, 1'b0, QM_WRITE, 8'h5A, 1'b1, 1'b0));

    target = tick_queue.size() + 1500;
    bits_left = 0;
    rd_byte = '0;
    while (tick_queue.size() < target) begin
      kind = $urandom_range(0, 9);
      wp = 1'($urandom_range(0, 1));
      en = ($urandom_range(0, 7) != 0);
      bus = 8'($urandom_range(0, 255));
      case (kind)
        0, 1, 2, 3, 4: begin
          // read a track: disk bytes MSB first at the sample phase, noise elsewhere
          len = $urandom_range(16, 96);
          for (int k = 0; k < len; k++) begin
            if ((tick_queue.size() % 8) == PHASE_SAMPLE) begin
              if (bits_left == 0 && $urandom_range(0, 3) == 0) begin
                dbit = 1'b0;
              end else begin
                if (bits_left == 0) begin
                  rd_byte = 8'($urandom_range(0, 255)) | 8'h80;
                  bits_left = 8;
                end
                dbit = rd_byte[7];
                rd_byte = {rd_byte[6:0], 1'b0};
                bits_left--;
              end
            end else begin
              dbit = 1'($urandom_range(0, 1));
            end
            tick_queue.push_back(make_tick(1'b1, dbit, QM_READ, bus, wp, en));
          end
        end
        5: begin
          // load a byte, then shift it out to the head
          len = $urandom_range(2, 8);
          for (int k = 0; k < len; k++)
            tick_queue.push_back(make_tick(1'b1, 1'($urandom_range(0, 1)), QM_LOAD, bus, wp,
                                           en));
          len = $urandom_range(16, 64);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 31) == 0) bus = 8'($urandom_range(0, 255));
            tick_queue.push_back(make_tick(1'b1, 1'($urandom_range(0, 1)), QM_WRITE, bus, wp,
                                           en));
          end
        end
        6: begin
          len = $urandom_range(8, 32);
          for (int k = 0; k < len; k++)
            tick_queue.push_back(make_tick(1'b1, 1'($urandom_range(0, 1)), QM_SENSE, bus, wp,
                                           en));
        end
        7: begin
          len = $urandom_range(4, 16);
          for (int k = 0; k < len; k++)
            tick_queue.push_back(dlss_item_t'(14'($urandom_range(0, 16'h3FFF))));
        end
        8: begin
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++)
            tick_queue.push_back(make_tick(1'b0, 1'($urandom_range(0, 1)),
                                           2'($urandom_range(0, 3)),
                                           8'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1))));
        end
        default: begin
          len = $urandom_range(8, 32);
          for (int k = 0; k < len; k++)
            tick_queue.push_back(make_tick(1'b1, 1'($urandom_range(0, 1)),
                                           2'($urandom_range(0, 3)),
                                           8'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1))));
        end
      endcase
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (tick_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dlss_pkg.sv
sv/dlss_step.sv
sv/disk_logic_state_sequencer.sv
dv/disk_logic_state_sequencer_tb.sv
